[rtl/fdrt_pkg.sv]
// shared types, codes and defaults for the deferred reclaim tracker
`timescale 1ns / 1ps
package fdrt_pkg;

    localparam int DEF_RESOURCE_SLOTS = 64;
    localparam int DEF_SERIAL_BITS    = 48;

    localparam logic [2:0] FUNC_CREATE   = 3'd0;
    localparam logic [2:0] FUNC_SUBMIT   = 3'd1;
    localparam logic [2:0] FUNC_RETIRE   = 3'd2;
    localparam logic [2:0] FUNC_COMPLETE = 3'd3;

    typedef struct packed {
        logic capture;
        logic rd_item;
        logic exec;
        logic rd_pend;
        logic rd_lu_pend;
        logic chk;
        logic sweep_end;
        logic list_rd;
        logic load_single;
        logic load_list;
    } t_cmd;

    typedef struct packed {
        logic is_complete;
        logic sweep_more;
        logic nrec_zero;
        logic list_last;
        logic out_free;
    } t_status;

endpackage

[rtl/fdrt_ctrl.sv]
// sequencer for the deferred reclaim tracker
`timescale 1ns / 1ps
module fdrt_ctrl import fdrt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_PUT    = 4'd3;
    localparam logic [3:0] S_SW_RDP = 4'd4;
    localparam logic [3:0] S_SW_RDL = 4'd5;
    localparam logic [3:0] S_SW_CHK = 4'd6;
    localparam logic [3:0] S_EM_RD  = 4'd7;
    localparam logic [3:0] S_EM_PUT = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_item = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_status.is_complete ? S_SW_RDP : S_PUT;
            end
            S_PUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_single = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SW_RDP: begin
                if (i_status.sweep_more) begin
                    o_cmd.rd_pend = 1'b1;
                    n_state = S_SW_RDL;
                end else begin
                    o_cmd.sweep_end = 1'b1;
                    n_state = i_status.nrec_zero ? S_PUT : S_EM_RD;
                end
            end
            S_SW_RDL: begin
                o_cmd.rd_lu_pend = 1'b1;
                n_state = S_SW_CHK;
            end
            S_SW_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = S_SW_RDP;
            end
            S_EM_RD: begin
                o_cmd.list_rd = 1'b1;
                n_state = S_EM_PUT;
            end
            S_EM_PUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_list = 1'b1;
                    n_state = i_status.list_last ? S_IDLE : S_EM_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[rtl/fdrt_dp.sv]
// state, memories and result register of the deferred reclaim tracker
`timescale 1ns / 1ps
module fdrt_dp import fdrt_pkg::*; #(
    parameter int RESOURCE_SLOTS = DEF_RESOURCE_SLOTS,
    parameter int SERIAL_BITS    = DEF_SERIAL_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [2:0]         i_func,
    input  logic [5:0]         i_resource_id,
    input  logic [47:0]        i_serial,
    input  logic signed [31:0] i_terminal_result,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_reclaim_valid,
    output logic [5:0]         o_reclaim_id,
    output logic [47:0]        o_assigned_serial,
    output logic               o_error_code,
    output logic               o_last,
    output logic [6:0]         o_live_count,
    output logic [6:0]         o_pending_count_out,
    output logic [31:0]        o_reclaimed_total,
    output logic [47:0]        o_submitted_serial_out,
    output logic [47:0]        o_completed_serial_out,
    output logic signed [31:0] o_terminal_result_out,
    output logic               o_has_capacity
);
    localparam int ID_W  = (RESOURCE_SLOTS > 1) ? $clog2(RESOURCE_SLOTS) : 1;
    localparam int CNT_W = $clog2(RESOURCE_SLOTS + 1);
    localparam logic [SERIAL_BITS-1:0] SER_ONES = '1;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(RESOURCE_SLOTS);

    logic [2:0]             r_func;
    logic [5:0]             r_id;
    logic [SERIAL_BITS-1:0] r_ser;
    logic [31:0]            r_term;

    logic [SERIAL_BITS-1:0] r_next;
    logic [SERIAL_BITS-1:0] r_sub;
    logic [SERIAL_BITS-1:0] r_comp;
    logic [31:0]            r_latch;
    logic [CNT_W-1:0]       r_pcnt;
    logic [CNT_W-1:0]       r_live;
    logic [31:0]            r_rcnt;
    logic [RESOURCE_SLOTS-1:0] r_slot_live;
    logic [RESOURCE_SLOTS-1:0] r_slot_pend;

    logic [SERIAL_BITS-1:0] mem_last_use [RESOURCE_SLOTS];
    logic [ID_W-1:0]        mem_pend     [RESOURCE_SLOTS];
    logic [ID_W-1:0]        mem_list     [RESOURCE_SLOTS];

    logic [SERIAL_BITS-1:0] r_lu_q;
    logic [ID_W-1:0]        r_pend_q;
    logic [ID_W-1:0]        r_list_q;

    logic [CNT_W-1:0] r_rd;
    logic [CNT_W-1:0] r_wr;
    logic [CNT_W-1:0] r_nrec;
    logic [CNT_W-1:0] r_em;

    logic                   r_rv;
    logic [5:0]             r_rid;
    logic [SERIAL_BITS-1:0] r_asg;
    logic                   r_err;

    logic                   r_out_valid;

    logic            in_range;
    logic [ID_W-1:0] idx;
    logic            held;
    logic            lu_done;
    logic            out_free;
    logic [ID_W-1:0] lu_addr;

    assign idx      = r_id[ID_W-1:0];
    assign in_range = ({1'b0, r_id} < 7'(RESOURCE_SLOTS));
    assign held     = in_range && r_slot_live[idx] && !r_slot_pend[idx];
    assign lu_done  = (r_lu_q <= r_comp);
    assign out_free = !r_out_valid || i_ready;
    assign lu_addr  = i_cmd.rd_lu_pend ? r_pend_q : idx;

    assign o_status.is_complete = (r_func == FUNC_COMPLETE);
    assign o_status.sweep_more  = (r_rd < r_pcnt);
    assign o_status.nrec_zero   = (r_nrec == '0);
    assign o_status.list_last   = (r_em == r_nrec - CNT_W'(1));
    assign o_status.out_free    = out_free;

    // memories: registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_item || i_cmd.rd_lu_pend) begin
            r_lu_q <= mem_last_use[lu_addr];
        end
        if (i_cmd.exec && held && r_func == FUNC_SUBMIT && r_next != SER_ONES) begin
            mem_last_use[idx] <= r_next;
        end else if (i_cmd.exec && in_range && r_func == FUNC_CREATE
                     && !r_slot_live[idx]) begin
            mem_last_use[idx] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_pend) begin
            r_pend_q <= mem_pend[r_rd[ID_W-1:0]];
        end
        if (i_cmd.exec && held && r_func == FUNC_RETIRE && !lu_done
            && r_pcnt < SLOTS_C) begin
            mem_pend[r_pcnt[ID_W-1:0]] <= idx;
        end else if (i_cmd.chk && !lu_done) begin
            mem_pend[r_wr[ID_W-1:0]] <= r_pend_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.list_rd) begin
            r_list_q <= mem_list[r_em[ID_W-1:0]];
        end
        if (i_cmd.chk && lu_done) begin
            mem_list[r_nrec[ID_W-1:0]] <= r_pend_q;
        end
    end

    // item capture and per-item result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_id   <= i_resource_id;
            r_ser  <= SERIAL_BITS'(i_serial);
            r_term <= i_terminal_result;
        end
        if (i_cmd.exec) begin
            r_rv  <= 1'b0;
            r_rid <= '0;
            r_asg <= '0;
            r_err <= 1'b0;
            if (r_func == FUNC_SUBMIT && held) begin
                if (r_next == SER_ONES) begin
                    r_err <= 1'b1;
                end else begin
                    r_asg <= r_next;
                end
            end
            if (r_func == FUNC_RETIRE && held && lu_done) begin
                r_rv  <= 1'b1;
                r_rid <= r_id;
            end
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next      <= SERIAL_BITS'(1);
            r_sub       <= '0;
            r_comp      <= '0;
            r_latch     <= '0;
            r_pcnt      <= '0;
            r_live      <= '0;
            r_rcnt      <= '0;
            r_slot_live <= '0;
            r_slot_pend <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_nrec      <= '0;
            r_em        <= '0;
        end else begin
            if (i_cmd.exec) begin
                unique case (r_func)
                    FUNC_CREATE: begin
                        if (in_range && !r_slot_live[idx]) begin
                            r_slot_live[idx] <= 1'b1;
                            r_slot_pend[idx] <= 1'b0;
                            r_live <= r_live + CNT_W'(1);
                        end
                    end
                    FUNC_SUBMIT: begin
                        if (held && r_next != SER_ONES) begin
                            r_next <= r_next + SERIAL_BITS'(1);
                            r_sub  <= r_next;
                        end
                    end
                    FUNC_RETIRE: begin
                        if (held) begin
                            if (lu_done) begin
                                r_slot_live[idx] <= 1'b0;
                                r_slot_pend[idx] <= 1'b0;
                                if (r_live != '0) r_live <= r_live - CNT_W'(1);
                                r_rcnt <= r_rcnt + 32'd1;
                            end else if (r_pcnt < SLOTS_C) begin
                                r_slot_pend[idx] <= 1'b1;
                                r_pcnt <= r_pcnt + CNT_W'(1);
                            end
                        end
                    end
                    FUNC_COMPLETE: begin
                        if (r_ser > r_comp) r_comp <= r_ser;
                        if (r_term != '0 && r_latch == '0) r_latch <= r_term;
                        r_rd   <= '0;
                        r_wr   <= '0;
                        r_nrec <= '0;
                        r_em   <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.chk) begin
                r_rd <= r_rd + CNT_W'(1);
                if (lu_done) begin
                    r_slot_live[r_pend_q] <= 1'b0;
                    r_slot_pend[r_pend_q] <= 1'b0;
                    if (r_live != '0) r_live <= r_live - CNT_W'(1);
                    r_rcnt <= r_rcnt + 32'd1;
                    r_nrec <= r_nrec + CNT_W'(1);
                end else begin
                    r_wr <= r_wr + CNT_W'(1);
                end
            end
            if (i_cmd.sweep_end) begin
                r_pcnt <= r_wr;
            end
            if (i_cmd.load_list) begin
                r_em <= r_em + CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_single || i_cmd.load_list) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single || i_cmd.load_list) begin
            o_reclaim_valid        <= i_cmd.load_list ? 1'b1 : r_rv;
            o_reclaim_id           <= i_cmd.load_list ? 6'(r_list_q) : r_rid;
            o_assigned_serial      <= i_cmd.load_list ? '0 : 48'(r_asg);
            o_error_code           <= i_cmd.load_list ? 1'b0 : r_err;
            o_last                 <= i_cmd.load_list ? o_status.list_last : 1'b1;
            o_live_count           <= 7'(r_live);
            o_pending_count_out    <= 7'(r_pcnt);
            o_reclaimed_total      <= r_rcnt;
            o_submitted_serial_out <= 48'(r_sub);
            o_completed_serial_out <= 48'(r_comp);
            o_terminal_result_out  <= r_latch;
            o_has_capacity         <= (r_next != SER_ONES);
        end
    end

    assign o_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_pcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= SLOTS_C) else $error("pending count above slot count");
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= SLOTS_C) else $error("live count above slot count");
    a_comp_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_comp >= $past(r_comp))
        else $error("completed serial went backwards");
    a_sweep_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= r_rd && r_em <= r_nrec) else $error("sweep index out of order");
`endif
endmodule

[rtl/fence_deferred_reclaim_tracker_core.sv]
// top level of the fence based deferred reclaim tracker
`timescale 1ns / 1ps
// tracks resource slots against submission serials: create, submit, retire,
// complete and query items each give one result, except complete, which
// reclaims every pending slot whose last use is now covered, oldest retire
// first, one result per reclaimed slot (or a single empty result). counter
// fields in every result show the state after the whole item. create,
// submit, retire and query read the slot's last-use entry, execute and then
// load the result register; complete then walks the pending slots one at a
// time (read pending order, read last use, check) and loads one result per
// reclaimed slot from the reclaim list, paced by the single read port of the
// last-use and pending-order memories. a result load waits while the output
// is stalled. one item is in flight at a time; a new item is taken while its
// predecessor's last result still waits in the output register.
// no clearing pass after reset: slot flags are flip-flops cleared at once.
module fence_deferred_reclaim_tracker_core import fdrt_pkg::*; #(
    parameter int RESOURCE_SLOTS = DEF_RESOURCE_SLOTS,
    parameter int SERIAL_BITS    = DEF_SERIAL_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_func,
    input  logic [5:0]         i_resource_id,
    input  logic [47:0]        i_serial,
    input  logic signed [31:0] i_terminal_result,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_reclaim_valid,
    output logic [5:0]         o_reclaim_id,
    output logic [47:0]        o_assigned_serial,
    output logic               o_error_code,
    output logic               o_last,
    output logic [6:0]         o_live_count,
    output logic [6:0]         o_pending_count_out,
    output logic [31:0]        o_reclaimed_total,
    output logic [47:0]        o_submitted_serial_out,
    output logic [47:0]        o_completed_serial_out,
    output logic signed [31:0] o_terminal_result_out,
    output logic               o_has_capacity
);
    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    fdrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    fdrt_dp #(
        .RESOURCE_SLOTS (RESOURCE_SLOTS),
        .SERIAL_BITS    (SERIAL_BITS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_status               (status),
        .i_func                 (i_func),
        .i_resource_id          (i_resource_id),
        .i_serial               (i_serial),
        .i_terminal_result      (i_terminal_result),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_reclaim_valid        (o_reclaim_valid),
        .o_reclaim_id           (o_reclaim_id),
        .o_assigned_serial      (o_assigned_serial),
        .o_error_code           (o_error_code),
        .o_last                 (o_last),
        .o_live_count           (o_live_count),
        .o_pending_count_out    (o_pending_count_out),
        .o_reclaimed_total      (o_reclaimed_total),
        .o_submitted_serial_out (o_submitted_serial_out),
        .o_completed_serial_out (o_completed_serial_out),
        .o_terminal_result_out  (o_terminal_result_out),
        .o_has_capacity         (o_has_capacity)
    );
endmodule
